FILE: hw/rtl/teqd_pkg.sv
// teqd_pkg: shared types and constants of the timed event queue dispatcher
// no dependencies
package teqd_pkg;
    localparam int NUM_QUEUES = 8;
    localparam int QUEUE_DEPTH = 256;
    localparam int MAX_RESULTS = 8;
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int DW = $clog2(QUEUE_DEPTH);
    localparam int CW = DW + 1;
    localparam int AW = QW + DW;
    localparam int SLOT_W = 56;
    localparam int RCW = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] ACT_CLAIM = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_COMMIT = 2'd2;
    localparam logic [1:0] ACT_TICK = 2'd3;

    localparam logic [2:0] KIND_ACCEPTED = 3'd0;
    localparam logic [2:0] KIND_GRANTED = 3'd1;
    localparam logic [2:0] KIND_NO_FREE = 3'd2;
    localparam logic [2:0] KIND_SENT = 3'd3;
    localparam logic [2:0] KIND_REJECTED = 3'd4;

    localparam logic [0:0] CFG_PAUSED = 1'd0;
    localparam logic [0:0] CFG_STOPPED = 1'd1;

    localparam logic [7:0] STATUS_HI_MASK = 8'hF0;
    localparam logic [7:0] STATUS_PROG = 8'hC0;
    localparam logic [7:0] STATUS_BEND = 8'hE0;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  queue_index;
        logic [31:0] event_offset;
        logic [7:0]  status_byte;
        logic [7:0]  data_one;
        logic [7:0]  data_two;
        logic [47:0] clock_now;
    } t_req;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [2:0] out_queue;
        logic [7:0] out_status;
        logic [7:0] out_data_one;
        logic [7:0] out_data_two;
        logic [1:0] byte_count;
        logic       last_of_run;
    } t_rsp;

    typedef struct packed {
        logic [31:0] offset;
        logic [7:0]  status;
        logic [7:0]  d1;
        logic [7:0]  d2;
    } t_slot;

    function automatic logic [1:0] msg_bytes(input logic [7:0] st);
        logic [7:0] hi;
        hi = st & STATUS_HI_MASK;
        return (hi == STATUS_PROG || hi == STATUS_BEND) ? 2'd2 : 2'd3;
    endfunction
endpackage

FILE: hw/rtl/teqd_req_if.sv
// teqd_req_if: request channel with valid/ready handshake
// depends on teqd_pkg
interface teqd_req_if;
    logic valid;
    logic ready;
    teqd_pkg::t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/teqd_rsp_if.sv
// teqd_rsp_if: result channel with valid/ready handshake
// depends on teqd_pkg
interface teqd_rsp_if;
    logic valid;
    logic ready;
    teqd_pkg::t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/teqd_ram.sv
// teqd_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module teqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/timed_event_queue_dispatcher_core.sv
// timed_event_queue_dispatcher_core: top level, queue control fsm over an event ram
// claim/commit answer from S_OUT; append: S_APP_RD decides, S_APP_RD/S_APP_CMP shift later
// events up until the place is found, then S_OUT; tick: S_TK_CHK per queue, S_TK_RD/S_TK_EVAL
// per active queue, last event from S_OUT; result-side stalls hold these; one request at a time
// reset clears all queue state and flags; the event ram is not cleared
// depends on teqd_pkg, teqd_req_if, teqd_rsp_if, teqd_ram
module timed_event_queue_dispatcher_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    teqd_req_if.sink             req,
    teqd_rsp_if.source           rsp,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_index,
    input  logic [0:0]           i_cfg_data
);
    localparam int QW = teqd_pkg::QW;
    localparam int CW = teqd_pkg::CW;
    localparam int AW = teqd_pkg::AW;
    localparam int DW = teqd_pkg::DW;

    typedef enum logic [2:0] {
        S_IDLE, S_APP_RD, S_APP_CMP, S_TK_CHK, S_TK_RD, S_TK_EVAL, S_OUT
    } t_state;

    t_state r_state;
    teqd_pkg::t_req r_req;
    logic r_paused, r_stopped;
    logic [teqd_pkg::NUM_QUEUES-1:0] r_active, r_loading;
    logic [CW-1:0] r_head [teqd_pkg::NUM_QUEUES];
    logic [CW-1:0] r_count [teqd_pkg::NUM_QUEUES];
    logic [47:0] r_start [teqd_pkg::NUM_QUEUES];
    logic [CW-1:0] r_pos;
    logic [QW-1:0] r_q;
    logic [teqd_pkg::RCW-1:0] r_sent;
    logic r_ovalid;
    teqd_pkg::t_rsp r_out;
    teqd_pkg::t_rsp r_hold;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [teqd_pkg::SLOT_W-1:0] ram_wdata, ram_rdata;
    teqd_pkg::t_slot rd_slot;

    teqd_ram #(.WIDTH(teqd_pkg::SLOT_W), .DEPTH(teqd_pkg::NUM_QUEUES * teqd_pkg::QUEUE_DEPTH))
        u_store (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );
    assign rd_slot = teqd_pkg::t_slot'(ram_rdata);

    logic idx_ok;
    logic [QW-1:0] idx_q;
    logic [QW-1:0] free_q;
    logic free_found;
    logic [48:0] due;
    logic last_q;
    logic [CW-1:0] head_inc;
    teqd_pkg::t_slot new_slot;

    assign idx_ok = ({29'd0, r_req.queue_index} < 32'(teqd_pkg::NUM_QUEUES));
    assign idx_q = QW'(r_req.queue_index);
    assign new_slot = '{offset: r_req.event_offset, status: r_req.status_byte,
                        d1: r_req.data_one, d2: r_req.data_two};
    assign due = {1'b0, r_start[r_q]} + {17'd0, rd_slot.offset};
    assign last_q = ({{(32-QW){1'b0}}, r_q} == 32'(teqd_pkg::NUM_QUEUES - 1));
    assign head_inc = r_head[r_q] + CW'(1);

    always_comb begin
        free_q = '0;
        free_found = 1'b0;
        for (int i = teqd_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
            if (!r_active[i] && !r_loading[i]) begin
                free_q = QW'(i);
                free_found = 1'b1;
            end
        end
    end

    // ram addressing: append reads pos-1 and writes pos; tick reads the head
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = {r_q, r_pos[DW-1:0]};
        ram_wdata = new_slot;
        ram_raddr = {r_q, r_pos[DW-1:0] - DW'(1)};
        if (r_state == S_TK_RD) begin
            ram_raddr = {r_q, r_head[r_q][DW-1:0]};
        end
        if (r_state == S_APP_CMP) begin
            ram_we = 1'b1;
            if (rd_slot.offset > r_req.event_offset) begin
                ram_wdata = ram_rdata;
            end
        end else if (r_state == S_APP_RD && r_pos == '0 &&
                     r_out.result_kind == teqd_pkg::KIND_ACCEPTED) begin
            ram_we = 1'b1;
        end
    end

    assign req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign rsp.valid = r_ovalid;
    assign rsp.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_paused <= 1'b0;
            r_stopped <= 1'b0;
            r_active <= '0;
            r_loading <= '0;
            r_ovalid <= 1'b0;
            r_sent <= '0;
            for (int i = 0; i < teqd_pkg::NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_count[i] <= '0;
                r_start[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    teqd_pkg::CFG_PAUSED: r_paused <= i_cfg_data[0];
                    teqd_pkg::CFG_STOPPED: r_stopped <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_ovalid && rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        r_req <= req.data;
                        r_out <= '{result_kind: teqd_pkg::KIND_REJECTED, out_queue: 3'd0,
                                   out_status: 8'd0, out_data_one: 8'd0,
                                   out_data_two: 8'd0, byte_count: 2'd3, last_of_run: 1'b1};
                        r_q <= '0;
                        r_sent <= '0;
                        case (req.data.action)
                            teqd_pkg::ACT_CLAIM: r_state <= S_OUT;
                            teqd_pkg::ACT_APPEND: r_state <= S_APP_RD;
                            teqd_pkg::ACT_COMMIT: r_state <= S_OUT;
                            teqd_pkg::ACT_TICK: begin
                                if (!(r_paused || r_stopped)) begin
                                    r_state <= S_TK_CHK;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_APP_RD: begin
                    // first cycle decides; later cycles are the shift loop
                    if (r_out.result_kind == teqd_pkg::KIND_REJECTED && r_sent == '0) begin
                        r_sent <= teqd_pkg::RCW'(1);
                        if (idx_ok && r_loading[idx_q] && !r_active[idx_q] &&
                            r_count[idx_q] < CW'(teqd_pkg::QUEUE_DEPTH)) begin
                            r_q <= idx_q;
                            r_pos <= r_count[idx_q];
                            r_count[idx_q] <= r_count[idx_q] + CW'(1);
                            r_out.result_kind <= teqd_pkg::KIND_ACCEPTED;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else if (r_pos == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_APP_CMP;
                    end
                end
                S_APP_CMP: begin
                    if (rd_slot.offset > r_req.event_offset) begin
                        r_pos <= r_pos - CW'(1);
                        r_state <= S_APP_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_TK_CHK: begin
                    if (r_active[r_q] && r_head[r_q] >= r_count[r_q]) begin
                        r_active[r_q] <= 1'b0;
                        r_loading[r_q] <= 1'b0;
                        r_head[r_q] <= '0;
                        r_count[r_q] <= '0;
                        r_start[r_q] <= '0;
                    end
                    if (r_active[r_q] && r_head[r_q] < r_count[r_q]) begin
                        // the output register must be free before the next event is read
                        if (!r_ovalid || rsp.ready) begin
                            r_state <= S_TK_RD;
                        end
                    end else if (last_q) begin
                        r_state <= (r_sent != '0) ? S_OUT : S_IDLE;
                    end else begin
                        r_q <= r_q + QW'(1);
                    end
                end
                S_TK_RD: r_state <= S_TK_EVAL;
                S_TK_EVAL: begin
                    if (due <= {1'b0, r_req.clock_now}) begin
                        // the previous send is released now that another one follows
                        if (r_sent != '0) begin
                            r_out <= r_hold;
                            r_ovalid <= 1'b1;
                        end
                        r_hold <= '{result_kind: teqd_pkg::KIND_SENT,
                                    out_queue: 3'(r_q), out_status: rd_slot.status,
                                    out_data_one: rd_slot.d1, out_data_two: rd_slot.d2,
                                    byte_count: teqd_pkg::msg_bytes(rd_slot.status),
                                    last_of_run: 1'b0};
                        r_sent <= r_sent + teqd_pkg::RCW'(1);
                        if (head_inc >= r_count[r_q]) begin
                            r_active[r_q] <= 1'b0;
                            r_loading[r_q] <= 1'b0;
                            r_head[r_q] <= '0;
                            r_count[r_q] <= '0;
                            r_start[r_q] <= '0;
                        end else begin
                            r_head[r_q] <= head_inc;
                        end
                        if (last_q ||
                            r_sent == teqd_pkg::RCW'(teqd_pkg::MAX_RESULTS - 1)) begin
                            r_state <= S_OUT;
                        end else begin
                            r_q <= r_q + QW'(1);
                            r_state <= S_TK_CHK;
                        end
                    end else if (last_q) begin
                        r_state <= (r_sent != '0) ? S_OUT : S_IDLE;
                    end else begin
                        r_q <= r_q + QW'(1);
                        r_state <= S_TK_CHK;
                    end
                end
                S_OUT: begin
                    if (r_req.action == teqd_pkg::ACT_TICK) begin
                        // final send of the tick carries the last-of-run flag
                        if (!r_ovalid) begin
                            r_out <= '{result_kind: r_hold.result_kind,
                                       out_queue: r_hold.out_queue,
                                       out_status: r_hold.out_status,
                                       out_data_one: r_hold.out_data_one,
                                       out_data_two: r_hold.out_data_two,
                                       byte_count: r_hold.byte_count,
                                       last_of_run: 1'b1};
                            r_ovalid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                        case (r_req.action)
                            teqd_pkg::ACT_CLAIM: begin
                                if (free_found) begin
                                    r_loading[free_q] <= 1'b1;
                                    r_out.result_kind <= teqd_pkg::KIND_GRANTED;
                                    r_out.out_queue <= 3'(free_q);
                                end else begin
                                    r_out.result_kind <= teqd_pkg::KIND_NO_FREE;
                                end
                            end
                            teqd_pkg::ACT_COMMIT: begin
                                if (idx_ok && r_loading[idx_q] && !r_active[idx_q]) begin
                                    if (r_count[idx_q] == '0) begin
                                        r_loading[idx_q] <= 1'b0;
                                        r_head[idx_q] <= '0;
                                        r_start[idx_q] <= '0;
                                    end else begin
                                        r_start[idx_q] <= r_req.clock_now;
                                        r_head[idx_q] <= '0;
                                        r_active[idx_q] <= 1'b1;
                                        r_loading[idx_q] <= 1'b0;
                                        r_out.result_kind <= teqd_pkg::KIND_ACCEPTED;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active & r_loading) == '0)
        else $error("queue both active and loading");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid && req.ready |=> r_state != S_IDLE || r_req.action == teqd_pkg::ACT_TICK)
        else $error("request dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent <= teqd_pkg::RCW'(teqd_pkg::MAX_RESULTS))
        else $error("result cap exceeded");
endmodule
